/* design/xsed_pkg.sv */
// ----------------------------------------------------------------------------
// xsed_pkg
// Shared types and constants of the cross-reference stream entry decoder:
// request and result structs, register fields, queue records and codes.
// ----------------------------------------------------------------------------
package xsed_pkg;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // configuration port address width (registers at 0, 4, 8)
  localparam int CFG_AW = 4;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TYPE_W   = 2'd0;
  localparam logic [1:0] REG_SECOND_W = 2'd1;
  localparam logic [1:0] REG_THIRD_W  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_HEADER = 2'd0,
    FUNC_DATA   = 2'd1,
    FUNC_END    = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    KIND_FREE       = 3'd0,
    KIND_USED       = 3'd1,
    KIND_COMPRESSED = 3'd2,
    KIND_DONE       = 3'd3,
    KIND_ERROR      = 3'd4
  } kind_t;

  // entry type reduced to what the decoder needs
  typedef enum logic [1:0] {
    ETYPE_FREE  = 2'd0,
    ETYPE_USED  = 2'd1,
    ETYPE_COMP  = 2'd2,
    ETYPE_OTHER = 2'd3
  } etype_t;

  typedef struct packed {
    logic [3:0] type_w;
    logic [3:0] second_w;
    logic [3:0] third_w;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] first_object;
    logic [31:0] entry_count;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] object_number;
    logic [31:0] ref_generation;
    logic [31:0] second_value;
    logic [31:0] third_value;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] obj;
    logic [31:0] sec;
    logic [31:0] third;
  } q_rec_t;

  // classify a full 64-bit type field value
  function automatic etype_t type_code(input logic [63:0] v);
    etype_t t;
    if (v[63:2] != '0) begin
      t = ETYPE_OTHER;
    end else begin
      case (v[1:0])
        2'd0:    t = ETYPE_FREE;
        2'd1:    t = ETYPE_USED;
        2'd2:    t = ETYPE_COMP;
        default: t = ETYPE_OTHER;
      endcase
    end
    return t;
  endfunction

endpackage

/* design/xsed_queue.sv */
// ----------------------------------------------------------------------------
// xsed_queue
// Short first-in first-out queue of decoded records between the front and
// the back; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module xsed_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  xsed_pkg::q_rec_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output xsed_pkg::q_rec_t rd_data
);
  import xsed_pkg::*;

  q_rec_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue fill count beyond depth");

endmodule

/* design/xsed_front.sv */
// ----------------------------------------------------------------------------
// xsed_front
// Accepts requests while the queue is not full, assembles big-endian entry fields
// one byte per cycle, tracks subsection state and pushes one record per result.
// ----------------------------------------------------------------------------
module xsed_front (
  input  logic               clk,
  input  logic               rst_n,
  input  xsed_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  xsed_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output xsed_pkg::q_rec_t   q_rec
);
  import xsed_pkg::*;

  localparam logic [1:0] F_TYPE   = 2'd0;
  localparam logic [1:0] F_SECOND = 2'd1;
  localparam logic [1:0] F_THIRD  = 2'd2;
  localparam logic [1:0] F_NONE   = 2'd3;

  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  nbytes_r, nbytes_nxt;
  logic [1:0]  fidx_r, fidx_nxt;
  etype_t      type_r, type_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] next_obj_r, next_obj_nxt;
  logic [31:0] left_r, left_nxt;

  logic        accept;
  logic [2:0]  nz;
  logic [1:0]  f;
  logic [1:0]  g;
  logic [3:0]  wf;
  logic [63:0] acc_shift;
  logic [3:0]  cnt_inc;
  etype_t      type_d, type_c;
  logic [31:0] sec_d, sec_c, third_c;
  logic        clean;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // field selection: first nonzero-width field from the current one, and after it
  always_comb begin
    nz = {cfg.third_w != '0, cfg.second_w != '0, cfg.type_w != '0};
    case (fidx_r)
      F_TYPE:   f = nz[0] ? F_TYPE : (nz[1] ? F_SECOND : (nz[2] ? F_THIRD : F_NONE));
      F_SECOND: f = nz[1] ? F_SECOND : (nz[2] ? F_THIRD : F_NONE);
      F_THIRD:  f = nz[2] ? F_THIRD : F_NONE;
      default:  f = F_NONE;
    endcase
    case (f)
      F_TYPE:   g = nz[1] ? F_SECOND : (nz[2] ? F_THIRD : F_NONE);
      F_SECOND: g = nz[2] ? F_THIRD : F_NONE;
      default:  g = F_NONE;
    endcase
    case (f)
      F_TYPE:   wf = cfg.type_w;
      F_SECOND: wf = cfg.second_w;
      F_THIRD:  wf = cfg.third_w;
      default:  wf = '0;
    endcase
  end

  // byte assembly and field values after skipped fields take defaults
  always_comb begin
    acc_shift = {acc_r[55:0], in_data.data_byte};
    cnt_inc   = nbytes_r + 4'd1;
    type_d    = (fidx_r == F_TYPE && f != F_TYPE) ? ETYPE_USED : type_r;
    sec_d     = (fidx_r != F_THIRD && f == F_THIRD) ? '0 : sec_r;
    type_c    = (f == F_TYPE) ? type_code(acc_shift) : type_d;
    if (f == F_SECOND) begin
      sec_c = acc_shift[31:0];
    end else if (f == F_TYPE) begin
      sec_c = nz[1] ? sec_r : '0;
    end else begin
      sec_c = sec_d;
    end
    third_c = (f == F_THIRD) ? acc_shift[31:0] : '0;
    clean   = (left_r == '0) && (fidx_r == F_TYPE) && (nbytes_r == '0);
  end

  // request handling and record generation
  always_comb begin
    acc_nxt      = acc_r;
    nbytes_nxt   = nbytes_r;
    fidx_nxt     = fidx_r;
    type_nxt     = type_r;
    sec_nxt      = sec_r;
    next_obj_nxt = next_obj_r;
    left_nxt     = left_r;
    q_push       = 1'b0;
    q_rec        = '{kind: KIND_ERROR, obj: '0, sec: '0, third: '0};
    if (accept) begin
      case (func_t'(in_data.func))
        FUNC_HEADER: begin
          if (left_r != '0 || nz == '0) begin
            q_push = 1'b1;
          end else begin
            next_obj_nxt = in_data.first_object;
            left_nxt     = in_data.entry_count;
            acc_nxt      = '0;
            nbytes_nxt   = '0;
            fidx_nxt     = F_TYPE;
          end
        end
        FUNC_END: begin
          q_push       = 1'b1;
          q_rec.kind   = clean ? KIND_DONE : KIND_ERROR;
          acc_nxt      = '0;
          nbytes_nxt   = '0;
          fidx_nxt     = F_TYPE;
          type_nxt     = ETYPE_FREE;
          sec_nxt      = '0;
          next_obj_nxt = '0;
          left_nxt     = '0;
        end
        FUNC_DATA: begin
          if (left_r != '0 && f != F_NONE) begin
            type_nxt = type_d;
            sec_nxt  = sec_d;
            if (cnt_inc < wf) begin
              acc_nxt    = acc_shift;
              nbytes_nxt = cnt_inc;
              fidx_nxt   = f;
            end else begin
              acc_nxt    = '0;
              nbytes_nxt = '0;
              type_nxt   = type_c;
              sec_nxt    = sec_c;
              if (g != F_NONE) begin
                fidx_nxt = g;
              end else begin
                // entry complete
                fidx_nxt     = F_TYPE;
                next_obj_nxt = next_obj_r + 32'd1;
                left_nxt     = left_r - 32'd1;
                if (type_c != ETYPE_OTHER) begin
                  q_push      = 1'b1;
                  q_rec.kind  = kind_t'({1'b0, type_c});
                  q_rec.obj   = next_obj_r;
                  q_rec.sec   = sec_c;
                  q_rec.third = third_c;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      nbytes_r   <= '0;
      fidx_r     <= F_TYPE;
      type_r     <= ETYPE_FREE;
      sec_r      <= '0;
      next_obj_r <= '0;
      left_r     <= '0;
    end else begin
      acc_r      <= acc_nxt;
      nbytes_r   <= nbytes_nxt;
      fidx_r     <= fidx_nxt;
      type_r     <= type_nxt;
      sec_r      <= sec_nxt;
      next_obj_r <= next_obj_nxt;
      left_r     <= left_nxt;
    end
  end

  a_fidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    fidx_r != F_NONE)
    else $error("field index out of range");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_valid && !q_full))
    else $error("record pushed without an accepted request");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == FUNC_END) |=>
      (left_r == '0 && fidx_r == F_TYPE && nbytes_r == '0))
    else $error("stream state not cleared after end marker");

endmodule

/* design/xsed_back.sv */
// ----------------------------------------------------------------------------
// xsed_back
// Takes records from the queue, forms the result fields and holds them in
// the output register until the result request is taken.
// ----------------------------------------------------------------------------
module xsed_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  xsed_pkg::q_rec_t    q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output xsed_pkg::out_item_t out_data
);
  import xsed_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t res;
  logic      take;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // output register free or being drained
  assign take  = !out_valid_r || out_ready;
  assign q_pop = q_valid && take;

  // result formatting; compressed entries carry generation zero
  always_comb begin
    res.kind           = q_rec.kind;
    res.object_number  = q_rec.obj;
    res.ref_generation = (q_rec.kind == KIND_COMPRESSED) ? '0 : q_rec.third;
    res.second_value   = q_rec.sec;
    res.third_value    = q_rec.third;
    out_valid_nxt      = take ? q_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_data_r.kind == $past(q_rec.kind)))
    else $error("popped record not loaded into output register");

endmodule

/* design/xref_stream_entry_decoder_top.sv */
// ----------------------------------------------------------------------------
// xref_stream_entry_decoder_top
// Path: each result is written into the queue, then into the output register.
// Throughput: one request per cycle while the queue is not full; the byte
// assembler in the front finishes every request in the cycle it is accepted.
// Reset: synchronous active-low; widths return to 1/2/1, stream state clears.
// ----------------------------------------------------------------------------
module xref_stream_entry_decoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  xsed_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output xsed_pkg::out_item_t        out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xsed_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import xsed_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       q_push, q_full, q_pop, q_valid;
  q_rec_t     q_wr, q_rd;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  // register write and read decode
  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (reg_idx)
      REG_TYPE_W: begin
        prdata = {28'd0, cfg_r.type_w};
        if (wr_en) cfg_nxt.type_w = pwdata[3:0];
      end
      REG_SECOND_W: begin
        prdata = {28'd0, cfg_r.second_w};
        if (wr_en) cfg_nxt.second_w = pwdata[3:0];
      end
      REG_THIRD_W: begin
        prdata = {28'd0, cfg_r.third_w};
        if (wr_en) cfg_nxt.third_w = pwdata[3:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{type_w: 4'd1, second_w: 4'd2, third_w: 4'd1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  xsed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_wr)
  );

  xsed_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  xsed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
